// File: design/imhc_pkg.sv
// Package for the indexed max-heap of counts: sizes, codes and types.
// No dependencies.
package imhc_pkg;
	localparam int CAPACITY   = 64;
	localparam int COUNT_BITS = 16;
	localparam int KEY_BITS   = 31;
	localparam int IDX_BITS   = $clog2(CAPACITY + 1);
	localparam int ADDR_BITS  = $clog2(CAPACITY);
	localparam int SLOT_BITS  = KEY_BITS + COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_INC    = 2'd1,
		FN_DEC    = 2'd2,
		FN_ERASE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2,
		ST_DUP     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SEARCH, S_DECIDE, S_FILL, S_UP_RD, S_UP_CMP, S_DN_RDL, S_DN_RDR,
		S_DN_CMP, S_SWAP_A, S_SWAP_B, S_TOP_RD, S_TOP_WAIT, S_OUT
	} state_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [COUNT_BITS-1:0] count;
	} slot_t;
endpackage

// File: design/imhc_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module imhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// File: design/indexed_max_heap_counts.sv
// Indexed max-heap of (key, count) entries; uses imhc_pkg and imhc_ram.
// Steps: accept, a linear key search over occupied slots, a decide step (plus a fill step
// to move the last entry on a removal), sift up per level (read parent, compare, swap A/B),
// sift down per level (read children, compare, swap A/B), end the sift, then fetch the top
// (read, wait) and present it. One request at a time through a single-port
// slot RAM; in_stall is high while busy. Reset: asynchronous, active low; clears occupancy
// and control, RAM contents undefined.
module indexed_max_heap_counts (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [imhc_pkg::KEY_BITS-1:0] key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [imhc_pkg::KEY_BITS-1:0] top_key,
	output logic [imhc_pkg::COUNT_BITS-1:0] top_count,
	output logic [6:0]                    occupancy,
	output logic [1:0]                    status
);
	import imhc_pkg::*;

	state_t state_q, state_d;
	logic [IDX_BITS-1:0] total_q, total_d;   // number of entries
	logic [IDX_BITS-1:0] idx_q, idx_d;       // search / sift position (1-based)
	logic [IDX_BITS-1:0] best_q, best_d;     // swap partner
	logic [IDX_BITS-1:0] found_q, found_d;
	logic [1:0]          func_q, func_d;
	logic [KEY_BITS-1:0] key_q, key_d;
	slot_t               cur_q, cur_d;       // slot value at idx_q
	slot_t               oth_q, oth_d;       // parent or best child
	logic                rdv_q, rdv_d;       // read issued last cycle
	logic                remove_q, remove_d; // after removal, sift up then down
	status_t             st_q, st_d;
	slot_t               top_q, top_d;

	// child positions, one bit wider so the last slot's children do not wrap
	logic [IDX_BITS:0]   lchild, rchild;

	logic                ram_we;
	logic [IDX_BITS-1:0] ram_idx;
	slot_t               ram_wdata, ram_rdata;

	assign lchild = {idx_q, 1'b0};
	assign rchild = {idx_q, 1'b1};

	imhc_ram #(.WIDTH(SLOT_BITS), .DEPTH(CAPACITY)) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.addr (ADDR_BITS'(ram_idx - 1'b1)),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			rdv_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			rdv_q   <= rdv_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d; best_q <= best_d; found_q <= found_d;
		func_q <= func_d; key_q <= key_d; cur_q <= cur_d; oth_q <= oth_d;
		remove_q <= remove_d; st_q <= st_d; top_q <= top_d;
	end

	always_comb begin
		state_d = state_q; total_d = total_q; idx_d = idx_q; best_d = best_q;
		found_d = found_q; func_d = func_q; key_d = key_q; cur_d = cur_q;
		oth_d = oth_q; rdv_d = 1'b0; remove_d = remove_q; st_d = st_q; top_d = top_q;
		ram_we = 1'b0; ram_idx = idx_q; ram_wdata = cur_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					func_d = func; key_d = key; idx_d = IDX_BITS'(1);
					found_d = '0; remove_d = 1'b0; st_d = ST_OK;
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				// one slot read a cycle; compare the data of the previous read
				ram_idx = idx_q;
				if (rdv_q && ram_rdata.key == key_q && found_q == '0) begin
					found_d = idx_q - 1'b1;
					cur_d = ram_rdata;
				end
				if (idx_q <= total_q && !(rdv_q && ram_rdata.key == key_q)) begin
					rdv_d = 1'b1;
					idx_d = idx_q + 1'b1;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (func_q == FN_INSERT) begin
					if (found_q != '0) begin
						st_d = ST_DUP; state_d = S_TOP_RD;
					end else if (total_q >= IDX_BITS'(CAPACITY)) begin
						st_d = ST_FULL; state_d = S_TOP_RD;
					end else begin
						total_d = total_q + 1'b1;
						idx_d = total_q + 1'b1;
						cur_d = '{key: key_q, count: COUNT_BITS'(1)};
						ram_we = 1'b1; ram_idx = total_q + 1'b1;
						ram_wdata = '{key: key_q, count: COUNT_BITS'(1)};
						state_d = S_UP_RD;
					end
				end else if (found_q == '0) begin
					st_d = ST_MISSING; state_d = S_TOP_RD;
				end else begin
					idx_d = found_q;
					if (func_q == FN_INC) begin
						if (cur_q.count != COUNT_MAX) cur_d.count = cur_q.count + 1'b1;
						ram_we = 1'b1; ram_idx = found_q; ram_wdata = cur_d;
						state_d = S_UP_RD;
					end else if (func_q == FN_DEC && cur_q.count > COUNT_BITS'(1)) begin
						cur_d.count = cur_q.count - 1'b1;
						ram_we = 1'b1; ram_idx = found_q; ram_wdata = cur_d;
						state_d = S_DN_RDL;
					end else begin
						// removal: move the last entry into the hole unless the hole is the last slot
						total_d = total_q - 1'b1;
						remove_d = 1'b1;
						ram_idx = total_q;
						if (found_q == total_q) state_d = S_TOP_RD;
						else state_d = S_FILL;
					end
				end
			end
			S_FILL: begin
				cur_d = ram_rdata;
				ram_we = 1'b1; ram_idx = idx_q; ram_wdata = ram_rdata;
				state_d = S_UP_RD;
			end
			S_UP_RD: begin
				ram_idx = idx_q >> 1;
				if (idx_q > IDX_BITS'(1)) state_d = S_UP_CMP;
				else state_d = remove_q ? S_DN_RDL : S_TOP_RD;
			end
			S_UP_CMP: begin
				oth_d = ram_rdata;
				if (ram_rdata.count < cur_q.count) begin
					best_d = idx_q >> 1; remove_d = 1'b0; state_d = S_SWAP_A;
				end else begin
					state_d = remove_q ? S_DN_RDL : S_TOP_RD;
				end
			end
			S_DN_RDL: begin
				remove_d = 1'b0;
				ram_idx = lchild[IDX_BITS-1:0];
				oth_d = cur_q; best_d = idx_q;
				if (lchild <= {1'b0, total_q}) state_d = S_DN_RDR;
				else state_d = S_TOP_RD;
			end
			S_DN_RDR: begin
				ram_idx = rchild[IDX_BITS-1:0];
				if (ram_rdata.count > oth_q.count) begin
					oth_d = ram_rdata; best_d = lchild[IDX_BITS-1:0];
				end
				if (rchild <= {1'b0, total_q}) state_d = S_DN_CMP;
				else state_d = S_SWAP_A;
			end
			S_DN_CMP: begin
				if (ram_rdata.count > oth_q.count) begin
					oth_d = ram_rdata; best_d = rchild[IDX_BITS-1:0];
				end
				state_d = S_SWAP_A;
			end
			S_SWAP_A: begin
				if (best_q == idx_q) begin
					state_d = S_TOP_RD;
				end else begin
					ram_we = 1'b1; ram_idx = idx_q; ram_wdata = oth_q;
					state_d = S_SWAP_B;
				end
			end
			S_SWAP_B: begin
				// cur moves to best; continue in the same direction
				ram_we = 1'b1; ram_idx = best_q; ram_wdata = cur_q;
				idx_d = best_q;
				state_d = (best_q < idx_q) ? S_UP_RD : S_DN_RDL;
			end
			S_TOP_RD: begin
				ram_idx = IDX_BITS'(1);
				state_d = S_TOP_WAIT;
			end
			S_TOP_WAIT: begin
				top_d = (total_q != '0) ? ram_rdata : '0;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign top_key   = top_q.key;
	assign top_count = top_q.count;
	assign occupancy = 7'(total_q);
	assign status    = st_q;

	// Occupancy never exceeds capacity.
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= IDX_BITS'(CAPACITY)) else $error("occupancy overflow");
	// A result is only shown after a request is taken and not while accepting.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall)) else $error("result while idle");
	// Occupancy holds while idle and on the cycle a request is taken.
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> (total_q == $past(total_q))) else $error("total moved");
	// Empty heap reports zero top.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_q == '0 |-> top_count == '0) else $error("empty top");
endmodule
